### design/mep_pkg.sv
// Shared types, constants and functions of the Mandelbrot escape-time pixel block.
package mep_pkg;

  // Iteration limit and largest picture dimension.
  localparam int ITER_LIMIT = 100;
  localparam int MAX_DIM    = 4096;

  // Field widths.
  localparam int COORD_W = 12;
  localparam int STEP_W  = 30;
  localparam int COLOR_W = 8;
  localparam int COUNT_W = 7;
  localparam int ITER_W  = $clog2(ITER_LIMIT + 1);
  localparam int HUE_W   = 9;

  // Q4.28 fixed point.
  localparam int FRAC_BITS = 28;
  localparam int Q_W       = 32;
  localparam int PROD_W    = 2 * Q_W;
  localparam int SUM_W     = 40;

  localparam logic signed [PROD_W-1:0] Q_MAX_WIDE = 64'sd2147483647;
  localparam logic signed [PROD_W-1:0] Q_MIN_WIDE = -64'sd2147483648;
  localparam logic signed [Q_W-1:0]    Q_MAX      = 32'sh7FFF_FFFF;
  localparam logic signed [Q_W-1:0]    Q_MIN      = 32'sh8000_0000;

  // Corner of the picture: -2.0 and -1.5, and the escape bound 4.0.
  localparam logic signed [PROD_W-1:0] C_RE_BASE = -(64'sd2 <<< FRAC_BITS);
  localparam logic signed [PROD_W-1:0] C_IM_BASE = -(64'sd3 <<< (FRAC_BITS - 1));
  localparam logic signed [SUM_W-1:0]  Q_FOUR    = 40'sd4 <<< FRAC_BITS;

  // Configuration register indexes and reset values.
  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] REG_REAL_STEP = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAG_STEP = 1'b1;
  localparam logic [STEP_W-1:0] REAL_STEP_RST = 30'd1260260;
  localparam logic [STEP_W-1:0] IMAG_STEP_RST = 30'd1681224;

  typedef struct packed {
    logic [STEP_W-1:0] real_step;
    logic [STEP_W-1:0] imag_step;
  } steps_t;

  // Operand pairs and products of the three-lane multiplier.
  typedef struct packed {
    logic signed [Q_W-1:0] a0;
    logic signed [Q_W-1:0] b0;
    logic signed [Q_W-1:0] a1;
    logic signed [Q_W-1:0] b1;
    logic signed [Q_W-1:0] a2;
    logic signed [Q_W-1:0] b2;
  } mul_req_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] p0;
    logic signed [PROD_W-1:0] p1;
    logic signed [PROD_W-1:0] p2;
  } mul_rsp_t;

  // Sequencer status toward the output stage.
  typedef struct packed {
    logic              done;
    logic [ITER_W-1:0] iter;
  } seq_stat_t;

  // Hue per iteration count, built at elaboration.
  typedef logic [HUE_W-1:0] hue_tbl_t [ITER_LIMIT+1];

  function automatic hue_tbl_t hue_build();
    hue_tbl_t t;
    for (int i = 0; i <= ITER_LIMIT; i++) begin
      t[i] = HUE_W'((i * 360) / ITER_LIMIT);
    end
    return t;
  endfunction

  localparam hue_tbl_t HUE_TABLE = hue_build();

  // Clip a wide signed value to the Q4.28 range.
  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [PROD_W-1:0] v);
    logic signed [Q_W-1:0] r;
    if (v > Q_MAX_WIDE) begin
      r = Q_MAX;
    end else if (v < Q_MIN_WIDE) begin
      r = Q_MIN;
    end else begin
      r = v[Q_W-1:0];
    end
    return r;
  endfunction

endpackage

### design/mep_pixel_if.sv
// Pixel coordinate channel.
interface mep_pixel_if;
  import mep_pkg::*;

  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] pixel_x;
  logic [COORD_W-1:0] pixel_y;

  modport source (output valid, pixel_x, pixel_y, input ready);
  modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

### design/mep_color_if.sv
// Pixel color result channel.
interface mep_color_if;
  import mep_pkg::*;

  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;
  logic [COUNT_W-1:0] iteration_count;
  logic               in_set;

  modport source (output valid, red, green, blue, iteration_count, in_set, input ready);
  modport sink   (input valid, red, green, blue, iteration_count, in_set, output ready);
endinterface

### design/mep_cfg_if.sv
// Configuration write channel.
interface mep_cfg_if;
  import mep_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [STEP_W-1:0]     data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

### design/mep_cfg_regs.sv
// Step registers written through the configuration channel.
module mep_cfg_regs (
  input  logic            clk_i,
  input  logic            rst_ni,
  mep_cfg_if.sink         cfg_i,
  output mep_pkg::steps_t steps_o
);
  import mep_pkg::*;

  steps_t steps_q, steps_d;

  assign cfg_i.ready = 1'b1;
  assign steps_o     = steps_q;

  always_comb begin
    steps_d = steps_q;
    if (cfg_i.valid) begin
      case (cfg_i.addr)
        REG_REAL_STEP: steps_d.real_step = cfg_i.data;
        REG_IMAG_STEP: steps_d.imag_step = cfg_i.data;
        default:       steps_d = steps_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q.real_step <= REAL_STEP_RST;
      steps_q.imag_step <= IMAG_STEP_RST;
    end else begin
      steps_q <= steps_d;
    end
  end

endmodule

### design/mep_mul_unit.sv
// Three registered 32x32 signed multipliers shared by all steps of a pixel.
module mep_mul_unit (
  input  logic              clk_i,
  input  mep_pkg::mul_req_t req_i,
  output mep_pkg::mul_rsp_t rsp_o
);
  import mep_pkg::*;

  mul_rsp_t rsp_q;

  always_ff @(posedge clk_i) begin
    rsp_q.p0 <= req_i.a0 * req_i.b0;
    rsp_q.p1 <= req_i.a1 * req_i.b1;
    rsp_q.p2 <= req_i.a2 * req_i.b2;
  end

  assign rsp_o = rsp_q;

endmodule

### design/mep_seq.sv
// Iteration sequencer: point setup, escape test and z update.
module mep_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  mep_pixel_if.sink          pix_i,
  input  mep_pkg::steps_t    steps_i,
  output mep_pkg::mul_req_t  mul_req_o,
  input  mep_pkg::mul_rsp_t  mul_rsp_i,
  output mep_pkg::seq_stat_t stat_o,
  input  logic               take_i
);
  import mep_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMUL = 3'd1;
  localparam logic [2:0] S_CSET = 3'd2;
  localparam logic [2:0] S_SQ   = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]            state_q, state_d;
  logic [ITER_W-1:0]     iter_q, iter_d;
  logic [ITER_W-1:0]     iter_inc;
  logic [COORD_W-1:0]    px_q, px_d, py_q, py_d;
  logic signed [Q_W-1:0] c_re_q, c_re_d, c_im_q, c_im_d;
  logic signed [Q_W-1:0] re_q, re_d, im_q, im_d;

  logic signed [SUM_W-1:0] rr, ii, ri, mag, re_wide, im_wide;
  logic                    escape;
  logic                    accept;

  assign accept      = pix_i.valid && pix_i.ready;
  assign pix_i.ready = (state_q == S_IDLE);
  assign stat_o.done = (state_q == S_DONE);
  assign stat_o.iter = iter_q;
  assign iter_inc    = ITER_W'(iter_q + 1'b1);

  // Floor-rounded squares and doubled cross product.
  assign rr      = SUM_W'(mul_rsp_i.p0 >>> FRAC_BITS);
  assign ii      = SUM_W'(mul_rsp_i.p1 >>> FRAC_BITS);
  assign ri      = SUM_W'(mul_rsp_i.p2 >>> (FRAC_BITS - 1));
  assign mag     = rr + ii;
  assign escape  = (mag > Q_FOUR);
  assign re_wide = rr - ii + SUM_W'(c_re_q);
  assign im_wide = ri + SUM_W'(c_im_q);

  always_comb begin
    mul_req_o.a0 = re_q;
    mul_req_o.b0 = re_q;
    mul_req_o.a1 = im_q;
    mul_req_o.b1 = im_q;
    mul_req_o.a2 = re_q;
    mul_req_o.b2 = im_q;
    if (state_q == S_CMUL) begin
      mul_req_o.a0 = Q_W'(px_q);
      mul_req_o.b0 = Q_W'(steps_i.real_step);
      mul_req_o.a1 = Q_W'(py_q);
      mul_req_o.b1 = Q_W'(steps_i.imag_step);
    end
  end

  always_comb begin
    state_d = state_q;
    iter_d  = iter_q;
    px_d    = px_q;
    py_d    = py_q;
    c_re_d  = c_re_q;
    c_im_d  = c_im_q;
    re_d    = re_q;
    im_d    = im_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          // Clamp coordinates past the picture edge.
          px_d = (32'(pix_i.pixel_x) >= MAX_DIM) ? COORD_W'(MAX_DIM - 1) : pix_i.pixel_x;
          py_d = (32'(pix_i.pixel_y) >= MAX_DIM) ? COORD_W'(MAX_DIM - 1) : pix_i.pixel_y;
          state_d = S_CMUL;
        end
      end
      S_CMUL: state_d = S_CSET;
      S_CSET: begin
        c_re_d  = sat_q(mul_rsp_i.p0 + C_RE_BASE);
        c_im_d  = sat_q(mul_rsp_i.p1 + C_IM_BASE);
        re_d    = '0;
        im_d    = '0;
        iter_d  = '0;
        state_d = S_SQ;
      end
      S_SQ: state_d = S_UPD;
      S_UPD: begin
        if (escape) begin
          state_d = S_DONE;
        end else begin
          re_d   = sat_q(PROD_W'(re_wide));
          im_d   = sat_q(PROD_W'(im_wide));
          iter_d = iter_inc;
          state_d = (iter_inc == ITER_W'(ITER_LIMIT)) ? S_DONE : S_SQ;
        end
      end
      S_DONE: begin
        if (take_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q   <= px_d;
    py_q   <= py_d;
    c_re_q <= c_re_d;
    c_im_q <= c_im_d;
    re_q   <= re_d;
    im_q   <= im_d;
  end

`ifndef ASSERT_OFF
  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iter_q <= ITER_W'(ITER_LIMIT))
    else $error("iteration count past limit");

  a_upd_after_sq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_UPD |-> $past(state_q) == S_SQ)
    else $error("update step without fresh products");

  a_take_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i |-> state_q == S_DONE)
    else $error("result taken while no pixel is finished");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_CMUL)
    else $error("accepted item did not start point setup");
`endif

endmodule

### design/mandelbrot_escape_pixel.sv
// Top level of the Mandelbrot escape-time pixel block.
//
//   channel  direction  payload                                   handshake
//   cfg_i    in         addr (0 real_step, 1 imag_step), data     valid/ready
//   pix_i    in         pixel_x, pixel_y                          valid/ready
//   col_o    out        red, green, blue, iteration_count, in_set valid/ready
//
// A pixel passes point setup (S_CMUL, S_CSET) after acceptance, then iterates
// until it escapes or reaches ITER_LIMIT inside the set, before its result is
// registered; each iteration is one pass through the shared three-lane
// multiplier (S_SQ) plus the escape test and z update (S_UPD).
// Reset clears the sequencer and output valid and loads the step reset values.
// The finished result waits in the output register; a stalled sink holds the
// sequencer in its done state, and pix_i is ready only when the sequencer is idle.
module mandelbrot_escape_pixel (
  input  logic        clk_i,
  input  logic        rst_ni,
  mep_cfg_if.sink     cfg_i,
  mep_pixel_if.sink   pix_i,
  mep_color_if.source col_o
);
  import mep_pkg::*;

  steps_t    steps;
  mul_req_t  mul_req;
  mul_rsp_t  mul_rsp;
  seq_stat_t stat;
  logic      take;

  logic               out_valid_q, out_valid_d;
  logic [COLOR_W-1:0] red_q, green_q, blue_q;
  logic [COUNT_W-1:0] count_q;
  logic               in_set_q;

  logic [HUE_W-1:0]   hue;
  logic               pix_in_set;

  mep_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_i),
    .steps_o (steps)
  );

  mep_mul_unit u_mul (
    .clk_i (clk_i),
    .req_i (mul_req),
    .rsp_o (mul_rsp)
  );

  mep_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pix_i     (pix_i),
    .steps_i   (steps),
    .mul_req_o (mul_req),
    .mul_rsp_i (mul_rsp),
    .stat_o    (stat),
    .take_i    (take)
  );

  // Load the output register when it is empty or being drained this cycle.
  assign take       = stat.done && (!out_valid_q || col_o.ready);
  assign pix_in_set = (stat.iter == ITER_W'(ITER_LIMIT));
  assign hue        = HUE_TABLE[stat.iter];

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (col_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Color from hue: red from the low seven bits, green and blue full on
  // bits seven and eight; black inside the set.
  always_ff @(posedge clk_i) begin
    if (take) begin
      count_q  <= COUNT_W'(stat.iter);
      in_set_q <= pix_in_set;
      if (pix_in_set) begin
        red_q   <= '0;
        green_q <= '0;
        blue_q  <= '0;
      end else begin
        red_q   <= {hue[6:0], 1'b0};
        green_q <= hue[7] ? '1 : '0;
        blue_q  <= hue[8] ? '1 : '0;
      end
    end
  end

  assign col_o.valid           = out_valid_q;
  assign col_o.red             = red_q;
  assign col_o.green           = green_q;
  assign col_o.blue            = blue_q;
  assign col_o.iteration_count = count_q;
  assign col_o.in_set          = in_set_q;

endmodule
